[sv/double_ended_arena_allocator_core_assert.svh]
// Assertion macros for the checker file of the arena allocator.
// No dependencies; include by bare file name.
`ifndef DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_ASSERT_SVH
`define DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dea_pkg.sv]
// Shared constants for the double-ended arena allocator: field widths,
// command, status and register codes, parameter defaults. No dependencies.
package dea_pkg;

	localparam int MARK_DEPTH_DEF = 8;
	localparam int ALIGN_BITS_DEF = 2;

	localparam int CMD_W    = 4;
	localparam int SIZE_W   = 24;
	localparam int ID_W     = 3;
	localparam int ADDR_W   = 32;
	localparam int MIDX_W   = 4;
	localparam int STATUS_W = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PACK_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACK_SIZE  = 1'd1;

	localparam logic [CMD_W-1:0] CMD_NEW_PACK    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC_LOW   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC_HIGH  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR_HIGH  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RESIZE_LAST = 4'd4;
	localparam logic [CMD_W-1:0] CMD_PUSH        = 4'd5;
	localparam logic [CMD_W-1:0] CMD_POP         = 4'd6;
	localparam logic [CMD_W-1:0] CMD_POP_TO      = 4'd7;
	localparam logic [CMD_W-1:0] CMD_CLEAR_LOW   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_QUERY       = 4'd9;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_MARK = 2'd2;

endpackage

[sv/dea_cmd_if.sv]
// Command channel of the arena allocator: valid/ready plus command fields.
// Depends on dea_pkg for field widths.
interface dea_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [dea_pkg::CMD_W-1:0]   command;
	logic [dea_pkg::SIZE_W-1:0]  req_size;
	logic [dea_pkg::ID_W-1:0]    mark_id;

	modport source (output valid, output command, output req_size, output mark_id,
		input ready);
	modport sink (input valid, input command, input req_size, input mark_id,
		output ready);
endinterface

[sv/dea_rsp_if.sv]
// Result channel of the arena allocator: valid/ready plus result fields.
// Depends on dea_pkg for field widths.
interface dea_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [dea_pkg::ADDR_W-1:0]    address;
	logic [dea_pkg::MIDX_W-1:0]    mark_index;
	logic [dea_pkg::SIZE_W-1:0]    free_bytes;
	logic [dea_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output address, output mark_index, output free_bytes,
		output status, input ready);
	modport sink (input valid, input address, input mark_index, input free_bytes,
		input status, output ready);
endinterface

[sv/double_ended_arena_allocator_core.sv]
// Double-ended arena allocator core: cursors, mark stack and result register.
// Depends on dea_pkg, dea_cmd_if and dea_rsp_if.
//
// One command is taken per clock while the result side accepts results, and every
// command returns exactly one result beat: the command is held in an input register,
// all cursor and mark updates are done in one pass of logic, and the result lands in
// an output register. The sustained rate is one command per cycle when the result
// side does not stall, set by the update loop on the cursor registers.
// Commands: new pack loads the arena from pack_start/pack_size; alloc low/high return
// the block start, with sizes rounded up to 2^ALIGN_BITS bytes (the free-space check
// uses the unrounded size and reports out of memory without changing state); clear
// high, resize last, push, pop, pop to, clear low and query act on the cursors and
// the mark stack as their names say; unused codes act as query. The mark stack is a
// small memory read when a command is accepted, so no clearing pass follows reset.
// Write pack_start and pack_size only while no command is in flight.
module double_ended_arena_allocator_core #(
	parameter int MARK_DEPTH = dea_pkg::MARK_DEPTH_DEF,
	parameter int ALIGN_BITS = dea_pkg::ALIGN_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_en,
	input  logic [dea_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dea_pkg::CFG_DATA_W-1:0]   cfg_data,
	dea_cmd_if.sink                          cmd,
	dea_rsp_if.source                        rsp
);

	localparam int CNT_W = $clog2(MARK_DEPTH + 1);
	localparam int IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
	localparam int SEL_W = (CNT_W > dea_pkg::ID_W) ? CNT_W : dea_pkg::ID_W;
	localparam int MI_W  = (CNT_W > dea_pkg::MIDX_W) ? CNT_W : dea_pkg::MIDX_W;
	localparam int RSZ_W = dea_pkg::SIZE_W + 1;
	localparam int AW    = dea_pkg::ADDR_W;
	localparam logic [RSZ_W-1:0] ALIGN_MASK = RSZ_W'((1 << ALIGN_BITS) - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(MARK_DEPTH);

	// configuration registers
	logic [AW-1:0]               pack_start_q;
	logic [dea_pkg::SIZE_W-1:0]  pack_size_q;

	// allocator state
	logic [AW-1:0]     low_q, high_q, end_q, base_q;
	logic [RSZ_W-1:0]  last_size_q;
	logic [CNT_W-1:0]  mark_cnt_q;
	logic [AW-1:0]     mark_mem [MARK_DEPTH];

	// input stage
	logic                          valid_s1;
	logic [dea_pkg::CMD_W-1:0]     cmd_s1;
	logic [dea_pkg::SIZE_W-1:0]    req_size_s1;
	logic [dea_pkg::ID_W-1:0]      mark_id_s1;
	logic [AW-1:0]                 rd_data_s1;
	logic                          byp_s1;
	logic [AW-1:0]                 byp_data_s1;

	// result register
	logic                           rsp_valid_q;
	logic [AW-1:0]                  address_q;
	logic [dea_pkg::MIDX_W-1:0]     mark_index_q;
	logic [dea_pkg::SIZE_W-1:0]     free_bytes_q;
	logic [dea_pkg::STATUS_W-1:0]   status_q;

	// update logic
	logic                           adv, accept;
	logic [AW-1:0]                  diff_now, diff_n, mark_rd;
	logic                           lacking;
	logic [RSZ_W-1:0]               round_sz;
	logic [AW-1:0]                  low_n, high_n, end_n, base_n, addr_n;
	logic [RSZ_W-1:0]               last_size_n;
	logic [CNT_W-1:0]               cnt_n, cnt_d;
	logic [MI_W-1:0]                midx_n;
	logic [dea_pkg::STATUS_W-1:0]   status_n;
	logic [dea_pkg::SIZE_W-1:0]     free_n;
	logic                           push_we;
	logic [SEL_W-1:0]               rd_sel;
	logic [IDX_W-1:0]               rd_addr, wr_addr;

	// Advance the input stage when the result register is free or being drained.
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign accept    = cmd.valid && cmd.ready;

	// Forward a push written on the same edge as the read.
	assign mark_rd = byp_s1 ? byp_data_s1 : rd_data_s1;

	always_comb begin
		diff_now    = high_q - low_q;
		lacking     = diff_now[AW-1] || (diff_now < AW'(req_size_s1));
		round_sz    = (RSZ_W'(req_size_s1) + ALIGN_MASK) & ~ALIGN_MASK;
		low_n       = low_q;
		high_n      = high_q;
		end_n       = end_q;
		base_n      = base_q;
		last_size_n = last_size_q;
		cnt_n       = mark_cnt_q;
		addr_n      = '0;
		midx_n      = '0;
		status_n    = dea_pkg::STATUS_OK;
		push_we     = 1'b0;
		case (cmd_s1)
			dea_pkg::CMD_NEW_PACK: begin
				base_n = pack_start_q;
				low_n  = pack_start_q;
				high_n = pack_start_q + AW'(pack_size_q);
				end_n  = pack_start_q + AW'(pack_size_q);
				cnt_n  = '0;
			end
			dea_pkg::CMD_ALLOC_LOW: begin
				if (lacking) begin
					status_n = dea_pkg::STATUS_NO_SPACE;
				end else begin
					last_size_n = round_sz;
					addr_n      = low_q;
					low_n       = low_q + AW'(round_sz);
				end
			end
			dea_pkg::CMD_ALLOC_HIGH: begin
				if (lacking) begin
					status_n = dea_pkg::STATUS_NO_SPACE;
				end else begin
					last_size_n = round_sz;
					high_n      = high_q - AW'(round_sz);
					addr_n      = high_q - AW'(round_sz);
				end
			end
			dea_pkg::CMD_CLEAR_HIGH: begin
				high_n = end_q;
			end
			dea_pkg::CMD_RESIZE_LAST: begin
				// no space check: the low cursor may run past the high cursor
				low_n       = low_q - AW'(last_size_q) + AW'(round_sz);
				addr_n      = low_q - AW'(last_size_q) + AW'(round_sz);
				last_size_n = round_sz;
			end
			dea_pkg::CMD_PUSH: begin
				midx_n = MI_W'(mark_cnt_q);
				if (mark_cnt_q < DEPTH_CNT) begin
					push_we = 1'b1;
					cnt_n   = mark_cnt_q + CNT_W'(1);
				end
			end
			dea_pkg::CMD_POP: begin
				if (mark_cnt_q != '0) begin
					cnt_n = mark_cnt_q - CNT_W'(1);
					low_n = mark_rd;
				end
			end
			dea_pkg::CMD_POP_TO: begin
				if (SEL_W'(mark_id_s1) >= SEL_W'(mark_cnt_q)) begin
					status_n = dea_pkg::STATUS_BAD_MARK;
				end else begin
					cnt_n = CNT_W'(mark_id_s1);
					low_n = mark_rd;
				end
			end
			dea_pkg::CMD_CLEAR_LOW: begin
				cnt_n = '0;
				low_n = base_q;
			end
			default: begin
			end
		endcase
		// free space after the command, clamped to the field range
		diff_n = high_n - low_n;
		if (diff_n[AW-1]) begin
			free_n = '0;
		end else if (|diff_n[AW-2:dea_pkg::SIZE_W]) begin
			free_n = '1;
		end else begin
			free_n = diff_n[dea_pkg::SIZE_W-1:0];
		end
	end

	// Read address: pop uses the count after the retiring command, others mark_id.
	always_comb begin
		cnt_d = adv ? cnt_n : mark_cnt_q;
		if (cmd.command == dea_pkg::CMD_POP) begin
			rd_sel = SEL_W'(cnt_d) - SEL_W'(1);
		end else begin
			rd_sel = SEL_W'(cmd.mark_id);
		end
		rd_addr = rd_sel[IDX_W-1:0];
		wr_addr = mark_cnt_q[IDX_W-1:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_start_q <= '0;
			pack_size_q  <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				dea_pkg::REG_PACK_START: pack_start_q <= cfg_data;
				dea_pkg::REG_PACK_SIZE:  pack_size_q  <= cfg_data[dea_pkg::SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// commit state when a command retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '0;
			end_q       <= '0;
			base_q      <= '0;
			last_size_q <= '0;
			mark_cnt_q  <= '0;
		end else if (adv) begin
			low_q       <= low_n;
			high_q      <= high_n;
			end_q       <= end_n;
			base_q      <= base_n;
			last_size_q <= last_size_n;
			mark_cnt_q  <= cnt_n;
		end
	end

	// mark stack memory: write on push, registered read on accept
	always_ff @(posedge clk) begin
		if (adv && push_we) begin
			mark_mem[wr_addr] <= low_q;
		end
		if (accept) begin
			rd_data_s1 <= mark_mem[rd_addr];
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// input stage payload and write-to-read bypass
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd.command;
			req_size_s1 <= cmd.req_size;
			mark_id_s1  <= cmd.mark_id;
			byp_s1      <= adv && push_we && (wr_addr == rd_addr);
			byp_data_s1 <= low_q;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			address_q    <= addr_n;
			mark_index_q <= midx_n[dea_pkg::MIDX_W-1:0];
			free_bytes_q <= free_n;
			status_q     <= status_n;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.address    = address_q;
	assign rsp.mark_index = mark_index_q;
	assign rsp.free_bytes = free_bytes_q;
	assign rsp.status     = status_q;

endmodule

[sv/dea_checker.sv]
// Port-level checks for the arena allocator core, attached by bind.
// Depends on dea_pkg and double_ended_arena_allocator_core_assert.svh.
`include "double_ended_arena_allocator_core_assert.svh"

module dea_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cmd_valid,
	input logic                             cmd_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [dea_pkg::ADDR_W-1:0]       rsp_address,
	input logic [dea_pkg::MIDX_W-1:0]       rsp_mark_index,
	input logic [dea_pkg::SIZE_W-1:0]       rsp_free_bytes,
	input logic [dea_pkg::STATUS_W-1:0]     rsp_status
);

	// a stalled result beat holds
	`DEA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_address) && $stable(rsp_mark_index) && $stable(rsp_free_bytes) && $stable(rsp_status), "dea_checker: stalled result changed")

	// a draining result side never stalls the command side
	`DEA_ASSERT_SAME(a_ready_flow, clk, arst_n, rsp_ready, cmd_ready, "dea_checker: command stalled while results drain")

	// unstalled, an accepted command reaches rsp via input and result registers
	`DEA_ASSERT_NEXT(a_latency, clk, arst_n, (cmd_valid && cmd_ready) ##1 rsp_ready, rsp_valid, "dea_checker: result missing after accepted command")

endmodule

bind double_ended_arena_allocator_core dea_checker u_dea_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_address    (rsp.address),
	.rsp_mark_index (rsp.mark_index),
	.rsp_free_bytes (rsp.free_bytes),
	.rsp_status     (rsp.status)
);
